// File: src/assert_macros.svh
// assertion macros used by the port-level checker file
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/pedq_pkg.sv
// shared types, constants and arithmetic helpers of the palette quantizer
// no dependencies
`default_nettype none

package pedq_pkg;

  // defaults for the top level parameters
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int MAX_LINE_WIDTH_DEF  = 1024;

  // fixed field and register widths
  localparam int COMP_W  = 8;
  localparam int CARRY_W = 12;
  localparam int LW_W    = 11;
  localparam int PS_W    = 9;
  localparam int DIST_W  = 15;
  localparam int IDX_W   = 8;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd1024;

  // configuration register indexes
  localparam logic [0:0] CFG_LINE_WIDTH   = 1'b0;
  localparam logic [0:0] CFG_PALETTE_SIZE = 1'b1;

  // input item kinds
  localparam logic REQ_PALETTE = 1'b0;
  localparam logic REQ_PIXEL   = 1'b1;

  // four components: [0] luma, [1] u, [2] v, [3] alpha
  typedef logic [3:0][COMP_W-1:0]  yuva_t;
  typedef logic [3:0][CARRY_W-1:0] carry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  // search unit controls
  typedef struct packed {
    logic en;
    logic first;
  } srch_ctl_t;

  // clamp a 14-bit sum to 12-bit signed
  function automatic logic [CARRY_W-1:0] sat12(input logic signed [13:0] v);
    logic [CARRY_W-1:0] r;
    if (v > 14'sd2047) begin
      r = 12'h7ff;
    end else if (v < -14'sd2048) begin
      r = 12'h800;
    end else begin
      r = v[CARRY_W-1:0];
    end
    return r;
  endfunction

  // divide by eight, rounding toward zero; result always fits 12 bits here
  function automatic logic [CARRY_W-1:0] div8_tz(input logic signed [15:0] v);
    logic signed [15:0] b;
    logic signed [15:0] q;
    b = v + (v[15] ? 16'sd7 : 16'sd0);
    q = b >>> 3;
    return q[CARRY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/pedq_ram.sv
// single-port-write, single-port-read synchronous ram with a registered read port
// depends on nothing
`default_nettype none

module pedq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/pedq_search.sv
// nearest-entry search: one palette entry per cycle while enabled, keeps the first minimum
// depends on pedq_pkg
`default_nettype none

module pedq_search
  import pedq_pkg::*;
#(
  parameter int PAL_W = 8
) (
  input  wire logic       clk,
  input  wire srch_ctl_t  ctl,
  input  wire logic [PAL_W-1:0] idx,
  input  wire yuva_t      pal_q,
  input  wire carry_t     adj,
  output logic [PAL_W-1:0] best_idx,
  output yuva_t           best_entry
);

  logic [3:0][CARRY_W-1:0] ad;
  logic [DIST_W-1:0]       dist_sum;
  logic [DIST_W-1:0]       best_dist_r;
  logic [PAL_W-1:0]        best_idx_r;
  yuva_t                   best_entry_r;

  // absolute differences and weighted sum, alpha counts twice
  always_comb begin
    logic signed [12:0] d;
    for (int k = 0; k < 4; k++) begin
      d = 13'(signed'(adj[k])) - $signed({5'd0, pal_q[k]});
      ad[k] = d[12] ? CARRY_W'(-d) : CARRY_W'(d);
    end
    dist_sum = DIST_W'(ad[0]) + DIST_W'(ad[1]) + DIST_W'(ad[2])
             + DIST_W'({ad[3], 1'b0});
  end

  // strict compare keeps the lowest index among equal distances
  always_ff @(posedge clk) begin
    if (ctl.en && (ctl.first || dist_sum < best_dist_r)) begin
      best_dist_r  <= dist_sum;
      best_idx_r   <= idx;
      best_entry_r <= pal_q;
    end
  end

  assign best_idx   = best_idx_r;
  assign best_entry = best_entry_r;

endmodule

`default_nettype wire

// File: src/palette_error_diffusion_quantizer.sv
// Palette writes are stored at acceptance, one every cycle while idle. A pixel passes
// read, a search over the effective palette size (skipped if empty) and finish, where
// its index is presented once the result register is free; no input is taken before
// then. The search reads one palette entry per cycle from the palette ram read port.
// Reset (rst_n, synchronous): sets line width 1024, clears control, palette size, row
// carry, fill count; unwritten columns read as zero through it, no clearing pass.
`default_nettype none

module palette_error_diffusion_quantizer
  import pedq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
  parameter int MAX_LINE_WIDTH  = MAX_LINE_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: entry_index[7:0], luma[15:8], chroma_u[23:16], chroma_v[31:24], alpha[39:32]
  input  wire logic [39:0] in_tdata,
  // tuser: req_type[0], region_start[1]
  input  wire logic [1:0]  in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: palette_index[7:0]
  output logic [7:0]       out_tdata,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);

  localparam int PAL_W = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
  localparam int COL_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int WID_W = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMP_W = (WID_W > LW_W) ? WID_W : LW_W;

  state_t             state_r, state_nxt;
  logic [LW_W-1:0]    lw_r;
  logic [PS_W-1:0]    ps_r;
  yuva_t              pix_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [COL_W-1:0]   counter_r;
  logic [WID_W-1:0]   fill_r;
  carry_t             row_r;
  carry_t             adj_r;
  logic [PAL_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic [7:0]         out_data_r;

  logic               in_fire, pix_fire, fin_go;
  logic [WID_W-1:0]   eff_w;
  logic [CNT_W-1:0]   eff_cnt;
  logic               pal_we, pal_re, col_we, search_last;
  logic [PAL_W-1:0]   pal_raddr;
  yuva_t              pal_q;
  carry_t             col_q, col_wdata, row_nxt, adj_nxt;
  logic [PAL_W-1:0]   best_idx;
  yuva_t              best_entry;
  srch_ctl_t          srch_ctl;
  logic [WID_W-1:0]   col_inc;

  assign in_fire  = in_tvalid && in_tready;
  assign pix_fire = in_fire && (in_tuser[0] == REQ_PIXEL);
  assign fin_go   = (state_r == ST_FINISH) && (!out_valid_r || out_tready);

  // effective line width and palette size
  always_comb begin
    logic [CMP_W-1:0] lwx;
    lwx = CMP_W'(lw_r);
    if (lwx == '0) begin
      eff_w = WID_W'(1);
    end else if (lwx > CMP_W'(MAX_LINE_WIDTH)) begin
      eff_w = WID_W'(MAX_LINE_WIDTH);
    end else begin
      eff_w = WID_W'(lwx);
    end
    eff_cnt = (ps_r > PS_W'(PALETTE_ENTRIES)) ? CNT_W'(PALETTE_ENTRIES) : CNT_W'(ps_r);
  end

  // column taken by an accepted pixel
  always_comb begin
    if (in_tuser[1] || (WID_W'(counter_r) >= eff_w)) begin
      col_nxt = '0;
    end else begin
      col_nxt = counter_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (pix_fire) state_nxt = ST_READ;
      ST_READ:   state_nxt = (eff_cnt == '0) ? ST_FINISH : ST_SEARCH;
      ST_SEARCH: if (search_last) state_nxt = ST_FINISH;
      ST_FINISH: if (fin_go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready      = (state_r == ST_IDLE);
    pal_re         = (state_r == ST_READ) || (state_r == ST_SEARCH);
    pal_raddr      = (state_r == ST_SEARCH) ? cnt_r + PAL_W'(1) : '0;
    col_we         = fin_go;
    srch_ctl.en    = (state_r == ST_SEARCH);
    srch_ctl.first = (cnt_r == '0);
  end

  assign search_last = (CNT_W'(cnt_r) + CNT_W'(1)) == eff_cnt;
  assign pal_we = in_fire && (in_tuser[0] == REQ_PALETTE) &&
                  (PS_W'(in_tdata[7:0]) < PS_W'(PALETTE_ENTRIES));
  assign cfg_ready = 1'b1;

  // adjusted pixel: column carry counts only for columns written since region start,
  // row carry only past the line start
  always_comb begin
    logic signed [13:0] s;
    logic               col_ok;
    col_ok = WID_W'(col_r) < fill_r;
    for (int k = 0; k < 4; k++) begin
      s = $signed({6'd0, pix_r[k]})
        + ((col_r == '0) ? 14'sd0 : 14'(signed'(row_r[k])))
        + (col_ok ? 14'(signed'(col_q[k])) : 14'sd0);
      adj_nxt[k] = sat12(s);
    end
  end

  // residual split 3/8 down the column, 5/8 along the row
  always_comb begin
    logic signed [12:0] res;
    for (int k = 0; k < 4; k++) begin
      if (eff_cnt == '0) begin
        res = '0;
      end else begin
        res = 13'(signed'(adj_r[k])) - $signed({5'd0, best_entry[k]});
      end
      col_wdata[k] = div8_tz(16'(res) * 16'sd3);
      row_nxt[k]   = div8_tz(16'(res) * 16'sd5);
    end
  end

  assign col_inc = WID_W'(col_r) + WID_W'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= LINE_WIDTH_RST;
      ps_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH:   lw_r <= cfg_data;
        CFG_PALETTE_SIZE: ps_r <= cfg_data[PS_W-1:0];
        default: ;
      endcase
    end
  end

  // control state, counters and row carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      counter_r   <= '0;
      fill_r      <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (pix_fire && in_tuser[1]) begin
        fill_r <= '0;
      end else if (fin_go && (WID_W'(col_r) == fill_r)) begin
        fill_r <= fill_r + WID_W'(1);
      end
      if (state_r == ST_READ) begin
        cnt_r <= '0;
      end else if (state_r == ST_SEARCH) begin
        cnt_r <= cnt_r + PAL_W'(1);
      end
      if (fin_go) begin
        row_r       <= row_nxt;
        counter_r   <= (col_inc >= eff_w) ? '0 : COL_W'(col_inc);
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pix_fire) begin
      pix_r <= yuva_t'(in_tdata[39:8]);
      col_r <= col_nxt;
    end
    if (state_r == ST_READ) begin
      adj_r <= adj_nxt;
    end
    if (fin_go) begin
      out_data_r <= (eff_cnt == '0) ? 8'd0 : IDX_W'(best_idx);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // palette store; written only while idle, so no overlap with the search reads
  pedq_ram #(
    .DEPTH (PALETTE_ENTRIES),
    .WIDTH (32)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_tdata[PAL_W-1:0]),
    .wdata (in_tdata[39:8]),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_q)
  );

  // column carry store; read at acceptance, written back at finish of the same pixel
  pedq_ram #(
    .DEPTH (MAX_LINE_WIDTH),
    .WIDTH (4 * CARRY_W)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_r),
    .wdata (col_wdata),
    .re    (pix_fire),
    .raddr (col_nxt),
    .rdata (col_q)
  );

  pedq_search #(
    .PAL_W (PAL_W)
  ) u_search (
    .clk        (clk),
    .ctl        (srch_ctl),
    .idx        (cnt_r),
    .pal_q      (pal_q),
    .adj        (adj_r),
    .best_idx   (best_idx),
    .best_entry (best_entry)
  );

endmodule

`default_nettype wire

// File: src/pedq_checker.sv
// port-level checks of the palette quantizer, bound to the top level
// depends on pedq_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module pedq_checker
  import pedq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  logic in_acc, pix_acc, pal_acc, cfg_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign pix_acc = in_acc && (in_tuser[0] == REQ_PIXEL);
  assign pal_acc = in_acc && (in_tuser[0] == REQ_PALETTE);
  assign cfg_acc = cfg_valid && cfg_ready;

  // a stalled result holds its value
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a pixel occupies the block: no input transaction right after it
  `ASSERT_NEXT(a_pix_busy, clk, rst_n, pix_acc, !in_tready)

  // a new result never appears in the cycle right after an input transaction
  `ASSERT_IMPL(a_no_instant, clk, rst_n, $rose(out_tvalid), !$past(in_acc))

  // a palette write produces no result
  `ASSERT_NEXT(a_pal_silent, clk, rst_n, pal_acc && !out_tvalid && !cfg_acc, !out_tvalid)

endmodule

bind palette_error_diffusion_quantizer pedq_checker u_pedq_checker (.*);

`default_nettype wire

// File: tb/sv/pedq_checker.sv
// checker for the palette error-diffusion quantizer: watches the three channels,
// predicts each pixel's palette index and compares it with the result stream
// depends on pedq_pkg for field types, register indexes and item kinds
module pedq_tb_checker
  import pedq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // tdata: entry_index[7:0], luma[15:8], chroma_u[23:16], chroma_v[31:24], alpha[39:32]
  input  logic [39:0] in_tdata,
  // tuser: req_type[0], region_start[1]
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // tdata: palette_index[7:0]
  input  logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output int          mismatch_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  // shadow of the block's registers and state
  logic [LW_W-1:0] line_width_q;
  logic [PS_W-1:0] palette_size_q;
  yuva_t           palette_mem [PALETTE_ENTRIES_DEF];
  int              col_carry [MAX_LINE_WIDTH_DEF][4];
  int              row_carry [4];
  int              col_pos;

  // palette indexes still owed by the block, oldest first
  logic [7:0]      expected_indices [$];

  function automatic int clamp12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic int absdiff(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // one pixel: diffuse carries in, search nearest entry, diffuse residual out
  function automatic logic [7:0] quantize_pixel(input yuva_t px, input logic new_region);
    int width;
    int count;
    int col;
    int best;
    int best_dist;
    int dist_val;
    int res;
    int adj [4];
    width = (line_width_q == 0) ? 1 :
            (line_width_q > MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF : int'(line_width_q);
    count = (palette_size_q > PALETTE_ENTRIES_DEF) ? PALETTE_ENTRIES_DEF : int'(palette_size_q);
    if (new_region) begin
      foreach (col_carry[c, k]) col_carry[c][k] = 0;
      col_pos = 0;
    end
    // counter beyond a shrunken line counts as a line start
    if (col_pos >= width) col_pos = 0;
    col = col_pos;
    if (col == 0) begin
      foreach (row_carry[k]) row_carry[k] = 0;
    end
    for (int k = 0; k < 4; k++) begin
      adj[k] = clamp12(int'(px[k]) + row_carry[k] + col_carry[col][k]);
    end
    // first entry with the smallest distance wins, alpha weighted twice
    best = 0;
    best_dist = 0;
    for (int j = 0; j < count; j++) begin
      dist_val = absdiff(int'(palette_mem[j][0]), adj[0])
               + absdiff(int'(palette_mem[j][1]), adj[1])
               + absdiff(int'(palette_mem[j][2]), adj[2])
               + 2 * absdiff(int'(palette_mem[j][3]), adj[3]);
      if (j == 0 || dist_val < best_dist) begin
        best_dist = dist_val;
        best = j;
      end
    end
    // empty palette leaves a zero residual
    for (int k = 0; k < 4; k++) begin
      res = (count != 0) ? adj[k] - int'(palette_mem[best][k]) : 0;
      col_carry[col][k] = clamp12((res * 3) / 8);
      row_carry[k] = clamp12((res * 5) / 8);
    end
    col_pos = col + 1;
    if (col_pos >= width) col_pos = 0;
    return best[7:0];
  endfunction

  // track every transaction in acceptance order
  always @(posedge clk) begin
    if (!rst_n) begin
      line_width_q = LINE_WIDTH_RST;
      palette_size_q = '0;
      foreach (col_carry[c, k]) col_carry[c][k] = 0;
      foreach (row_carry[k]) row_carry[k] = 0;
      col_pos = 0;
      expected_indices.delete();
      mismatch_count = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LINE_WIDTH:   line_width_q = cfg_data;
          CFG_PALETTE_SIZE: palette_size_q = cfg_data[PS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == REQ_PALETTE) begin
          palette_mem[in_tdata[7:0]] = in_tdata[39:8];
        end else begin
          expected_indices.push_back(quantize_pixel(in_tdata[39:8], in_tuser[1]));
        end
      end
      if (out_tvalid && out_tready) begin
        if (expected_indices.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: result index %0d arrived with no pixel pending", $time, out_tdata);
          mismatch_count++;
        end else begin
          if (out_tdata !== expected_indices[0]) begin
            if (mismatch_count < MAX_REPORTS)
              $display("%0t: palette_index expected %0d, got %0d", $time,
                       expected_indices[0], out_tdata);
            mismatch_count++;
          end
          void'(expected_indices.pop_front());
        end
      end
      outstanding <= expected_indices.size();
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// top of the palette quantizer testbench: clock, reset, stimulus and verdict
// depends on pedq_pkg, palette_error_diffusion_quantizer and pedq_tb_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pedq_pkg::*;

  localparam int CLK_PERIOD       = 20;
  localparam int RESET_CYCLES     = 12;
  localparam int TOTAL_ITEMS      = 1030;
  localparam int PAUSE_CYCLES     = 4;
  localparam int DRAIN_CYCLES     = 300;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT      = 4000;
  localparam int LOAD_PHASE       = 1;
  localparam int HOLD_PHASE       = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_LINE_WIDTH;
  logic [10:0] cfg_data = '0;

  int          mismatch_count;
  int          outstanding;
  int          quiet_cycles = 0;

  // stimulus bookkeeping
  int          tx_max_gap = 0;
  int          rx_max_stall = 0;
  logic        hold_go = 1'b0;
  int          items_sent = 0;
  bit          loaded [PALETTE_ENTRIES_DEF];
  int          prefix = 0;
  int          phase;
  int          burst;
  logic [10:0] lw_pick;
  logic [8:0]  ps_pick;

  always #(CLK_PERIOD / 2) clk = ~clk;

  palette_error_diffusion_quantizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pedq_tb_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  function automatic logic [7:0] pick_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // components lean toward the extremes now and then
  function automatic yuva_t pick_color();
    yuva_t c;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 7))
        0: c[k] = 8'h00;
        1: c[k] = 8'hff;
        default: c[k] = pick_byte();
      endcase
    end
    return c;
  endfunction

  // offer one item after a random gap and hold it until the transaction
  task automatic send_item(input logic req, input logic [7:0] idx, input yuva_t px,
                           input logic region);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {px, idx};
    in_tuser <= {region, req};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // palette write, keeping track of how many leading entries are safe to search
  task automatic load_entry(input logic [7:0] idx, input yuva_t px);
    send_item(REQ_PALETTE, idx, px, $urandom_range(0, 3) == 0);
    loaded[idx] = 1'b1;
    while (prefix < PALETTE_ENTRIES_DEF && loaded[prefix]) prefix++;
  endtask

  // stop offering, let every pending index come back, then a short pause
  task automatic drain_results(input int extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(input logic [10:0] width, input logic [8:0] size);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data <= width;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PALETTE_SIZE;
    cfg_data <= {2'b00, size};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int stall;
    bit long_hold_done;
    long_hold_done = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = $urandom_range(0, rx_max_stall);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL palette_error_diffusion_quantizer");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    tx_max_gap = 3;
    rx_max_stall = 3;

    // empty palette after reset, then the lowest and highest entries
    send_item(REQ_PIXEL, pick_byte(), '0, 1'b1);
    send_item(REQ_PIXEL, pick_byte(), '1, 1'b0);
    load_entry(8'd0, '1);
    load_entry(8'd255, 32'h6c93_a51e);
    drain_results(PAUSE_CYCLES);

    // one bright entry against dark pixels drives the carries negative
    write_config(11'd3, 9'd1);
    for (int i = 0; i < 7; i++) send_item(REQ_PIXEL, pick_byte(), '0, i == 0);
    // one dark entry against bright pixels drives them positive
    load_entry(8'd0, '0);
    for (int i = 0; i < 7; i++) send_item(REQ_PIXEL, pick_byte(), '1, i == 0);
    // mixed entry and a duplicate of entry 0 for the tie rule
    load_entry(8'd1, '1);
    load_entry(8'd2, {8'hff, 8'h00, 8'hff, 8'h00});
    load_entry(8'd3, '0);
    drain_results(PAUSE_CYCLES);

    // zero line width behaves as one
    write_config(11'd0, 9'd4);
    send_item(REQ_PIXEL, pick_byte(), 32'h8080_8080, 1'b1);
    send_item(REQ_PIXEL, pick_byte(), {8'hff, 8'h00, 8'hff, 8'h00}, 1'b0);
    send_item(REQ_PIXEL, pick_byte(), pick_color(), 1'b0);

    // random phases, each with its own settings and idle pattern
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      drain_results(PAUSE_CYCLES);
      case ($urandom_range(0, 9))
        0: lw_pick = 11'd0;
        1: lw_pick = 11'd1;
        2: lw_pick = 11'd1024;
        3: lw_pick = 11'($urandom_range(1025, 2046));
        4: lw_pick = 11'd2047;
        default: lw_pick = 11'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 9))
        0: ps_pick = 9'd0;
        1: ps_pick = 9'(prefix);
        2: ps_pick = (prefix == PALETTE_ENTRIES_DEF) ? 9'($urandom_range(257, 511)) :
                     9'(prefix);
        default: ps_pick = (prefix == 0) ? 9'd0 :
                           9'($urandom_range(1, (prefix < 16) ? prefix : 16));
      endcase
      if (phase == HOLD_PHASE) ps_pick = 9'd4;
      write_config(lw_pick, ps_pick);
      case ($urandom_range(0, 2))
        0: tx_max_gap = 0;
        1: tx_max_gap = 14;
        default: tx_max_gap = 2;
      endcase
      case ($urandom_range(0, 2))
        0: rx_max_stall = 0;
        1: rx_max_stall = 14;
        default: rx_max_stall = 2;
      endcase
      if (phase == LOAD_PHASE) begin
        // whole palette so that full searches become legal
        for (int e = 0; e < PALETTE_ENTRIES_DEF; e++) load_entry(e[7:0], pick_color());
      end else begin
        burst = $urandom_range(15, 60);
        if (phase == HOLD_PHASE) begin
          // input keeps coming while the result side is held off
          tx_max_gap = 0;
          burst = 60;
          hold_go <= 1'b1;
        end
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 4) == 0) begin
            load_entry(($urandom_range(0, 1) == 0 || prefix >= PALETTE_ENTRIES_DEF) ?
                       pick_byte() : prefix[7:0], pick_color());
          end else begin
            send_item(REQ_PIXEL, pick_byte(), pick_color(),
                      ($urandom_range(0, 24) == 0) || (k == 0 && $urandom_range(0, 1) == 1));
          end
        end
      end
      phase++;
    end

    drain_results(DRAIN_CYCLES);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS palette_error_diffusion_quantizer");
    end else begin
      $display("FAIL palette_error_diffusion_quantizer");
    end
    $finish;
  end

endmodule
